// ----- design/box_blur_3x3_edge_normalized_unit_defines.svh -----
// ----------------------------------------------------------------------------
// box blur assertion macros
// shared assertion helpers, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BB3_NEVER(lbl, cond, msg) `BB3_ASSERT(lbl, !(cond), msg)
`else
`define BB3_ASSERT(lbl, prop, msg)
`define BB3_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/bb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// shared types and constants of the 3x3 box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int unsigned OUT_COL_W    = 10;
  localparam int unsigned OUT_ROW_W    = 12;
  localparam int unsigned OUT_SAMPLE_W = 8;
  localparam int unsigned IN_SAMPLE_W  = 8;
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;

  // position and edge flags of one accepted pixel
  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 c_ge1;
    logic                 c_ge2;
    logic                 r_ge1;
    logic                 r_ge2;
    logic                 last_col;
    logic                 last_row;
  } job_ctl_t;

endpackage

// ----- design/bb3_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                           wr_data_i,
  input  logic                                       rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                           rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/bb3_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_unit_defines.svh"

module bb3_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `BB3_NEVER(a_no_overflow, push_i && full_o, "job queue written while full")
  `BB3_NEVER(a_no_underflow, pop_i && empty_o, "job queue read while empty")

endmodule

// ----- design/bb3_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_front
// pixel intake: position counters, line stores and job building
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_unit_defines.svh"

module bb3_front #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]     in_red_i,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]     in_green_i,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]     in_blue_i,
  input  logic                                cfg_we_i,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                push_o,
  input  logic                                full_i,
  output bb3_pkg::job_ctl_t                   job_ctl_o,
  output logic [9*SAMPLE_BITS-1:0]            job_pix_o
);

  localparam int unsigned PIX_W = 3 * SAMPLE_BITS;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned EW    = (CW + 1 > bb3_pkg::CFG_WIDTH_W) ? CW + 1
                                                                  : bb3_pkg::CFG_WIDTH_W;
  localparam int unsigned HW    = (RW + 1 > bb3_pkg::CFG_HEIGHT_W) ? RW + 1
                                                                   : bb3_pkg::CFG_HEIGHT_W;
  localparam int unsigned IW    = (SAMPLE_BITS > bb3_pkg::IN_SAMPLE_W) ? SAMPLE_BITS
                                                                       : bb3_pkg::IN_SAMPLE_W;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_PUSH = 1'b1;

  logic                             st_q, st_d;
  logic [bb3_pkg::CFG_WIDTH_W-1:0]  width_q, width_d;
  logic [bb3_pkg::CFG_HEIGHT_W-1:0] height_q, height_d;
  logic [CW-1:0]                    col_q, col_d, addr_q;
  logic [RW-1:0]                    row_q, row_d;
  logic [EW-1:0]                    eff_w;
  logic [HW-1:0]                    eff_h;
  logic                             last_col, last_row, accept;
  logic [PIX_W-1:0]                 pix_q, in_pix, upper_rd, lower_rd;
  logic [IW-1:0]                    red_ext, green_ext, blue_ext;
  bb3_pkg::job_ctl_t                ctl_q, ctl_d;

  // clamp the size registers to the usable range
  always_comb begin
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (HW'(height_q) > HW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  assign last_col   = (EW'(col_q) + EW'(1) == eff_w);
  assign last_row   = (HW'(row_q) + HW'(1) == eff_h);
  assign in_stall_o = (st_q == F_PUSH);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (st_q == F_PUSH) && !full_i;

  assign red_ext   = IW'(in_red_i);
  assign green_ext = IW'(in_green_i);
  assign blue_ext  = IW'(in_blue_i);
  assign in_pix    = {blue_ext[SAMPLE_BITS-1:0], green_ext[SAMPLE_BITS-1:0],
                      red_ext[SAMPLE_BITS-1:0]};

  always_comb begin
    ctl_d          = ctl_q;
    ctl_d.col      = bb3_pkg::OUT_COL_W'(col_q);
    ctl_d.row      = bb3_pkg::OUT_ROW_W'(row_q);
    ctl_d.c_ge1    = (col_q != '0);
    ctl_d.c_ge2    = (EW'(col_q) > EW'(1));
    ctl_d.r_ge1    = (row_q != '0);
    ctl_d.r_ge2    = (HW'(row_q) > HW'(1));
    ctl_d.last_col = last_col;
    ctl_d.last_row = last_row;
  end

  always_comb begin
    st_d     = st_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bb3_pkg::REG_IMAGE_WIDTH: begin
          width_d = bb3_pkg::CFG_WIDTH_W'(cfg_data_i);
        end
        bb3_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
        end
        default: begin
          width_d = width_q;
        end
      endcase
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      st_d = F_PUSH;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (push_o) begin
      st_d = F_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= F_IDLE;
      width_q  <= bb3_pkg::WIDTH_RESET;
      height_q <= bb3_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      st_q     <= st_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= in_pix;
      ctl_q  <= ctl_d;
      addr_q <= col_q;
    end
  end

  // upper store takes the old lower row, lower store the new pixel
  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_store (
    .clk_i     (clk_i),
    .wr_en_i   (push_o),
    .wr_addr_i (addr_q),
    .wr_data_i (lower_rd),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (upper_rd)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lower_store (
    .clk_i     (clk_i),
    .wr_en_i   (push_o),
    .wr_addr_i (addr_q),
    .wr_data_i (pix_q),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (lower_rd)
  );

  assign job_ctl_o = ctl_q;
  assign job_pix_o = {pix_q, lower_rd, upper_rd};

  `BB3_NEVER(a_col_in_range, EW'(col_q) >= eff_w, "column counter beyond row width")

endmodule

// ----- design/bb3_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_back
// window registers, masked sums and mean per result, output register
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_normalized_unit_defines.svh"

module bb3_back #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  output logic                               pop_o,
  input  bb3_pkg::job_ctl_t                  job_ctl_i,
  input  logic [9*SAMPLE_BITS-1:0]           job_pix_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0]   out_red_o,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0]   out_green_o,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0]   out_blue_o,
  output logic [bb3_pkg::OUT_COL_W-1:0]      out_column_o,
  output logic [bb3_pkg::OUT_ROW_W-1:0]      out_row_o,
  output logic                               last_of_run_o,
  output logic                               end_of_frame_o
);

  localparam int unsigned PIX_W = 3 * SAMPLE_BITS;
  localparam int unsigned COL_W = 3 * PIX_W;
  localparam int unsigned SUM_W = SAMPLE_BITS + 4;
  localparam int unsigned K     = SUM_W + 4;
  localparam int unsigned RCP_W = K + 1;
  localparam int unsigned QW    = (SUM_W > bb3_pkg::OUT_SAMPLE_W) ? SUM_W
                                                                  : bb3_pkg::OUT_SAMPLE_W;

  // rounded-up reciprocals, exact truncating divide for sums below 2**SUM_W
  localparam logic [RCP_W-1:0] RCP1 = RCP_W'((64'd1 << K));
  localparam logic [RCP_W-1:0] RCP2 = RCP_W'(((64'd1 << K) + 64'd1) / 64'd2);
  localparam logic [RCP_W-1:0] RCP3 = RCP_W'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [RCP_W-1:0] RCP4 = RCP_W'(((64'd1 << K) + 64'd3) / 64'd4);
  localparam logic [RCP_W-1:0] RCP6 = RCP_W'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic [RCP_W-1:0] RCP9 = RCP_W'(((64'd1 << K) + 64'd8) / 64'd9);

  localparam logic [3:0] CNT1 = 4'd1;
  localparam logic [3:0] CNT2 = 4'd2;
  localparam logic [3:0] CNT3 = 4'd3;
  localparam logic [3:0] CNT4 = 4'd4;
  localparam logic [3:0] CNT6 = 4'd6;
  localparam logic [3:0] CNT9 = 4'd9;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SUM  = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;

  // result slots: bit 0 picks the right-edge form, bit 1 the bottom-row form
  localparam logic [1:0] RES_EOF = 2'd3;

  logic [1:0]             st_q, st_d;
  bb3_pkg::job_ctl_t      ctl_q;
  logic [COL_W-1:0]       cur_q, w0_q, w1_q;
  logic [3:0]             en_q, en_new, rest;
  logic [1:0]             idx_q, first_new, nxt;
  logic                   has_next, out_free, load_out;

  logic [COL_W-1:0]       col_a, col_b;
  logic                   m_a, m_c, m_r0, m_r1;
  logic [2:0]             rmask;
  logic [1:0]             ncol, nrow;
  logic [SUM_W-1:0]       sum_d [3];
  logic [SUM_W-1:0]       sum_q [3];
  logic [3:0]             cnt_q;
  logic [bb3_pkg::OUT_COL_W-1:0] res_col_q;
  logic [bb3_pkg::OUT_ROW_W-1:0] res_row_q;
  logic                   res_eof_q, res_last_q;
  logic [RCP_W-1:0]       rcp;
  logic [QW-1:0]          mean [3];

  logic                   out_valid_q;
  logic [bb3_pkg::OUT_SAMPLE_W-1:0] red_q, green_q, blue_q;
  logic [bb3_pkg::OUT_COL_W-1:0]    column_q;
  logic [bb3_pkg::OUT_ROW_W-1:0]    row_q;
  logic                             last_of_run_q, end_of_frame_q;

  // results that a job causes
  assign en_new = {job_ctl_i.last_row & job_ctl_i.last_col,
                   job_ctl_i.last_row & job_ctl_i.c_ge1,
                   job_ctl_i.r_ge1 & job_ctl_i.last_col,
                   job_ctl_i.r_ge1 & job_ctl_i.c_ge1};

  always_comb begin
    first_new = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (en_new[i]) begin
        first_new = 2'(i);
      end
    end
    nxt = 2'd0;
    for (int i = 0; i < 4; i++) begin
      rest[i] = en_q[i] && (2'(i) > idx_q);
    end
    for (int i = 3; i >= 0; i--) begin
      if (rest[i]) begin
        nxt = 2'(i);
      end
    end
  end

  assign has_next = |rest;

  // masks of the current result slot
  always_comb begin
    col_a = idx_q[0] ? w0_q : w1_q;
    col_b = idx_q[0] ? cur_q : w0_q;
    m_a   = idx_q[0] ? ctl_q.c_ge1 : ctl_q.c_ge2;
    m_c   = !idx_q[0];
    m_r0  = idx_q[1] ? 1'b0 : ctl_q.r_ge2;
    m_r1  = idx_q[1] ? ctl_q.r_ge1 : 1'b1;
    rmask = {1'b1, m_r1, m_r0};
    ncol  = 2'(m_a) + 2'd1 + 2'(m_c);
    nrow  = 2'(m_r0) + 2'(m_r1) + 2'd1;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int j = 0; j < 3; j++) begin
        if (rmask[j]) begin
          if (m_a) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(col_a[j*PIX_W + ch*SAMPLE_BITS +: SAMPLE_BITS]);
          end
          sum_d[ch] = sum_d[ch] + SUM_W'(col_b[j*PIX_W + ch*SAMPLE_BITS +: SAMPLE_BITS]);
          if (m_c) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(cur_q[j*PIX_W + ch*SAMPLE_BITS +: SAMPLE_BITS]);
          end
        end
      end
    end
  end

  always_comb begin
    unique case (cnt_q)
      CNT1:    rcp = RCP1;
      CNT2:    rcp = RCP2;
      CNT3:    rcp = RCP3;
      CNT4:    rcp = RCP4;
      CNT6:    rcp = RCP6;
      CNT9:    rcp = RCP9;
      default: rcp = RCP1;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      mean[ch] = QW'(({{RCP_W{1'b0}}, sum_q[ch]} * {{SUM_W{1'b0}}, rcp}) >> K);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (st_q == B_IDLE) && !empty_i;
  assign load_out = (st_q == B_MUL) && out_free;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (pop_o && (en_new != '0)) begin
          st_d = B_SUM;
        end
      end
      B_SUM: begin
        st_d = B_MUL;
      end
      B_MUL: begin
        if (out_free) begin
          st_d = has_next ? B_SUM : B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
      w0_q        <= '0;
      w1_q        <= '0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // shift the window once every result of the job is out
      if (pop_o && (en_new == '0)) begin
        w1_q <= w0_q;
        w0_q <= job_pix_i;
      end else if (load_out && !has_next) begin
        w1_q <= w0_q;
        w0_q <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ctl_q <= job_ctl_i;
      cur_q <= job_pix_i;
      en_q  <= en_new;
      idx_q <= first_new;
    end else if (load_out && has_next) begin
      idx_q <= nxt;
    end
    if (st_q == B_SUM) begin
      sum_q      <= sum_d;
      cnt_q      <= 4'(ncol) * 4'(nrow);
      res_col_q  <= idx_q[0] ? ctl_q.col : ctl_q.col - bb3_pkg::OUT_COL_W'(1);
      res_row_q  <= idx_q[1] ? ctl_q.row : ctl_q.row - bb3_pkg::OUT_ROW_W'(1);
      res_eof_q  <= (idx_q == RES_EOF);
      res_last_q <= !has_next;
    end
    if (load_out) begin
      red_q          <= mean[0][bb3_pkg::OUT_SAMPLE_W-1:0];
      green_q        <= mean[1][bb3_pkg::OUT_SAMPLE_W-1:0];
      blue_q         <= mean[2][bb3_pkg::OUT_SAMPLE_W-1:0];
      column_q       <= res_col_q;
      row_q          <= res_row_q;
      last_of_run_q  <= res_last_q;
      end_of_frame_q <= res_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = red_q;
  assign out_green_o    = green_q;
  assign out_blue_o     = blue_q;
  assign out_column_o   = column_q;
  assign out_row_o      = row_q;
  assign last_of_run_o  = last_of_run_q;
  assign end_of_frame_o = end_of_frame_q;

  `BB3_ASSERT(a_slot_enabled, (st_q != B_IDLE) |-> en_q[idx_q], "working on a disabled slot")
  `BB3_ASSERT(a_eof_is_last, (out_valid_q && end_of_frame_q) |-> last_of_run_q, "eof not last")

endmodule

// ----- design/box_blur_3x3_edge_normalized_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_unit
// streaming 3x3 box blur, mean over the in-image part of each window
// ----------------------------------------------------------------------------
// Pixels enter in raster order, three channels each. Every output pixel is
// the truncated per-channel mean of its 3x3 neighbors that lie inside the
// image (divide by 9, 6, 4 or fewer at edges and corners) and comes out with
// its column and row once its lower-right neighbor has been taken in; the
// outputs of the last row follow that row's input, so one pixel yields 0 to
// 4 results. The front reads the line stores as it takes a pixel, then
// writes them and pushes the job, taking no new pixel until the push. The
// back takes a job, then per result forms the window sum and then the
// reciprocal multiply into the output register; the back's sum and
// multiply steps set the sustained rate. A two-entry job queue lets both
// halves stall on their own. Line stores have no reset and no clearing
// pass: rows that are not yet in the frame are masked out. Any write of
// image_width or image_height restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_unit #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]  in_red_i,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]  in_green_i,
  input  logic [bb3_pkg::IN_SAMPLE_W-1:0]  in_blue_i,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // blurred output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0] out_red_o,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0] out_green_o,
  output logic [bb3_pkg::OUT_SAMPLE_W-1:0] out_blue_o,
  output logic [bb3_pkg::OUT_COL_W-1:0]    out_column_o,
  output logic [bb3_pkg::OUT_ROW_W-1:0]    out_row_o,
  output logic                             last_of_run_o,
  output logic                             end_of_frame_o
);

  localparam int unsigned PIXS_W = 9 * SAMPLE_BITS;
  localparam int unsigned JOB_W  = $bits(bb3_pkg::job_ctl_t) + PIXS_W;

  // front to queue
  logic              push, full;
  bb3_pkg::job_ctl_t f_ctl;
  logic [PIXS_W-1:0] f_pix;

  // queue to back
  logic              pop, empty;
  logic [JOB_W-1:0]  q_job;
  bb3_pkg::job_ctl_t b_ctl;
  logic [PIXS_W-1:0] b_pix;

  // counters, size registers and both line stores
  bb3_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .full_i      (full),
    .job_ctl_o   (f_ctl),
    .job_pix_o   (f_pix)
  );

  // job = edge flags, position and the new column of three pixels
  bb3_fifo #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_pix}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_job),
    .empty_o (empty)
  );

  assign b_ctl = q_job[JOB_W-1:PIXS_W];
  assign b_pix = q_job[PIXS_W-1:0];

  // window, sums, means and the output register
  bb3_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_o          (pop),
    .job_ctl_i      (b_ctl),
    .job_pix_i      (b_pix),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

// ----- tb/bb3_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_checker
// watches the pixel and blur channels, predicts every blurred pixel and
// compares each output transfer with the oldest prediction
// ----------------------------------------------------------------------------
module bb3_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [7:0]                       in_red_i,
  input  logic [7:0]                       in_green_i,
  input  logic [7:0]                       in_blue_i,
  input  logic                             cfg_we_i,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [7:0]                       out_red_i,
  input  logic [7:0]                       out_green_i,
  input  logic [7:0]                       out_blue_i,
  input  logic [9:0]                       out_column_i,
  input  logic [11:0]                      out_row_i,
  input  logic                             last_of_run_i,
  input  logic                             end_of_frame_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               blurred_seen_o
);

  typedef struct packed {
    logic [7:0] r, g, b;
  } rgb_t;

  typedef struct packed {
    logic [7:0]  r, g, b;
    logic [9:0]  col;
    logic [11:0] row;
    logic        last;
    logic        eof;
  } blurred_t;

  rgb_t     upper_line[1024];
  rgb_t     lower_line[1024];
  rgb_t     win_prev[3];   // column c-1, rows r-2..r
  rgb_t     win_prev2[3];  // column c-2
  int       col_pos, row_pos;
  int       width_reg, height_reg;
  blurred_t blurred_q[$];

  // mean over columns a, b, c picked by colmask bits 0..2, and masked rows
  function automatic blurred_t window_mean(rgb_t a[3], rgb_t b[3], rgb_t c[3],
                                           int colmask, int rowmask,
                                           int x, int y, bit eof);
    int       sr, sg, sb, n;
    rgb_t     px;
    blurred_t o;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int i = 0; i < 3; i++) begin
      if (colmask[i]) begin
        for (int j = 0; j < 3; j++) begin
          if (rowmask[j]) begin
            px = (i == 0) ? a[j] : (i == 1) ? b[j] : c[j];
            sr += px.r; sg += px.g; sb += px.b; n++;
          end
        end
      end
    end
    if (n == 0) n = 1;
    o.r = 8'(sr / n); o.g = 8'(sg / n); o.b = 8'(sb / n);
    o.col = 10'(x); o.row = 12'(y); o.last = 1'b0; o.eof = eof;
    return o;
  endfunction

  task automatic predict_pixel(rgb_t px);
    int   w, h, c, r, rm, n0;
    bit   lc, lr;
    rgb_t cur[3];
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
    c = col_pos; r = row_pos;
    lc = (c + 1 == w); lr = (r + 1 == h);
    cur[0] = upper_line[c]; cur[1] = lower_line[c]; cur[2] = px;
    n0 = blurred_q.size();
    if (r >= 1) begin
      rm = (r >= 2 ? 1 : 0) | 6;
      if (c >= 1)
        blurred_q.push_back(window_mean(win_prev2, win_prev, cur,
          (c >= 2 ? 1 : 0) | 6, rm, c - 1, r - 1, 0));
      if (lc)
        blurred_q.push_back(window_mean(win_prev, cur, cur,
          (c >= 1 ? 1 : 0) | 2, rm, c, r - 1, 0));
    end
    if (lr) begin
      rm = (r >= 1 ? 2 : 0) | 4;
      if (c >= 1)
        blurred_q.push_back(window_mean(win_prev2, win_prev, cur,
          (c >= 2 ? 1 : 0) | 6, rm, c - 1, r, 0));
      if (lc)
        blurred_q.push_back(window_mean(win_prev, cur, cur,
          (c >= 1 ? 1 : 0) | 2, rm, c, r, 1));
    end
    if (blurred_q.size() > n0) blurred_q[$].last = 1'b1;
    upper_line[c] = cur[1];
    lower_line[c] = cur[2];
    win_prev2 = win_prev;
    win_prev = cur;
    c++;
    if (c >= w) begin
      c = 0; r++;
      if (r >= h) r = 0;
    end
    col_pos = c; row_pos = r;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0; blurred_seen_o = 0;
    col_pos = 0; row_pos = 0;
    width_reg = int'(bb3_pkg::WIDTH_RESET); height_reg = int'(bb3_pkg::HEIGHT_RESET);
    for (int i = 0; i < 3; i++) begin
      win_prev[i] = '0; win_prev2[i] = '0;
    end
    for (int i = 0; i < 1024; i++) begin
      upper_line[i] = '0; lower_line[i] = '0;
    end
  end

  assign pending_o = blurred_q.size();

  always @(posedge clk_i) begin
    blurred_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        blurred_seen_o++;
        if (blurred_q.size() == 0) begin
          report_mismatch("unexpected output transfer, column", out_column_i, -1);
        end else begin
          want = blurred_q.pop_front();
          if (out_red_i != want.r) report_mismatch("red", out_red_i, want.r);
          if (out_green_i != want.g) report_mismatch("green", out_green_i, want.g);
          if (out_blue_i != want.b) report_mismatch("blue", out_blue_i, want.b);
          if (out_column_i != want.col) report_mismatch("column", out_column_i, want.col);
          if (out_row_i != want.row) report_mismatch("row", out_row_i, want.row);
          if (last_of_run_i != want.last) report_mismatch("last", last_of_run_i, want.last);
          if (end_of_frame_i != want.eof) report_mismatch("eof", end_of_frame_i, want.eof);
        end
      end
      if (in_valid_i && !in_stall_i) predict_pixel({in_red_i, in_green_i, in_blue_i});
      if (cfg_we_i) begin
        if (cfg_index_i == bb3_pkg::REG_IMAGE_WIDTH)
          width_reg = int'(cfg_data_i[bb3_pkg::CFG_WIDTH_W-1:0]);
        else height_reg = int'(cfg_data_i);
        col_pos = 0; row_pos = 0;
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives frames of random pixels through the box blur at several sizes
// ----------------------------------------------------------------------------
// Each phase programs a frame size while the block is idle, then sends one or
// more whole frames (and sometimes a broken partial one) with random gaps on
// the pixel side and random stalls on the output side. A checker beside the
// block predicts and compares every blurred pixel.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic cfg_we = 1'b0;
  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic out_valid, out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic [9:0] out_column;
  logic [11:0] out_row;
  logic last_of_run, end_of_frame;
  int fail_count, pending, blurred_seen;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int idle_cycles = 0, pixels_sent = 0, frames_sent = 0;

  always #6 clk_i = ~clk_i;

  box_blur_3x3_edge_normalized_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .out_column_o(out_column), .out_row_o(out_row),
    .last_of_run_o(last_of_run), .end_of_frame_o(end_of_frame)
  );

  bb3_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_red_i(in_red), .in_green_i(in_green), .in_blue_i(in_blue),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_red_i(out_red), .out_green_i(out_green), .out_blue_i(out_blue),
    .out_column_i(out_column), .out_row_i(out_row),
    .last_of_run_i(last_of_run), .end_of_frame_i(end_of_frame),
    .fail_count_o(fail_count), .pending_o(pending), .blurred_seen_o(blurred_seen)
  );

  // receiver stalls on the falling edge
  always @(negedge clk_i) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d predictions outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // one pixel transfer; valid stays high into the next pixel if no gap
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_red <= r; in_green <= g; in_blue <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    // last pixel of a run may still be inside the block
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bb3_pkg::CFG_INDEX_W-1:0] idx, int value);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= bb3_pkg::CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // kind 0 random rgb, 1 random red only, 2 bilevel red, 3 extremes
  task automatic send_frame(int npix, int kind);
    logic [7:0] v;
    for (int i = 0; i < npix; i++) begin
      case (kind)
        0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        1: begin
          v = 8'($urandom); send_pixel(v, 8'd0, 8'd0);
        end
        2: send_pixel($urandom_range(1) ? 8'd255 : 8'd0, 8'd0, 8'd0);
        default: begin
          v = $urandom_range(1) ? 8'hff : 8'h00; send_pixel(v, v, v);
        end
      endcase
    end
    frames_sent++;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  initial begin
    int w, h, phase;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: corner cases of the frame size, extremes of the samples
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 1); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 1);
    send_frame(1, 3); send_frame(1, 3); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 0); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 0);
    send_frame(1, 0); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 1); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 4);
    send_frame(4, 3); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 5); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 1);
    send_frame(5, 3); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 3); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 3);
    send_frame(4, 2); drain;             // broken frame, restarted by a write
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 2); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 2);
    send_frame(4, 1); drain;

    // random phases, mostly whole frames of small sizes
    phase = 0;
    while (pixels_sent < 230) begin
      set_idling(phase);
      w = $urandom_range(1, 6); h = $urandom_range(1, 5);
      write_reg(bb3_pkg::REG_IMAGE_WIDTH, w); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, h);
      repeat ($urandom_range(1, 2)) send_frame(w * h, $urandom_range(3));
      if ($urandom_range(3) == 0) send_frame($urandom_range(1, w * h), 0);
      drain;   // sender waits for every prediction
      phase++;
    end

    // oversize sizes clamp to maximum; starts of wide 1-row, tall, full frames
    set_idling(0);
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 2047); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 1);
    send_frame(20, 0); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 2); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 8191);
    send_frame(6, 0); drain;
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 1024); write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 4096);
    send_frame(4, 0); drain;

    $display("sent %0d pixels in %0d frames over %0d phases, checked %0d outputs",
             pixels_sent, frames_sent, phase, blurred_seen);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
